[rtl/rk4_pkg.sv]
// types, constants, microcode program and arithmetic helpers for the rk4 integrator
`default_nettype none

package rk4_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 24;
  localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
  localparam int STEP_BITS   = 10;
  localparam int MAX_STEPS   = 1023;
  localparam int STEP_WIDTH  = 31;
  localparam int ADDR_WIDTH  = 4;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH-1:0]        umag_t;
  typedef logic [PROD_WIDTH-1:0]         prod_t;
  typedef logic [STEP_BITS-1:0]          steps_t;
  typedef logic [1:0]                    stage_t;

  localparam value_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // ceil(2^32 / 3): exact floor(x / 3) for x below 2^31
  localparam umag_t RECIP3 = umag_t'(64'd1431655766);

  localparam stage_t LAST_STAGE = 2'd3;

  typedef enum logic [1:0] {
    REG_STEP_SIZE    = 2'd0,
    REG_COEFF_SQUARE = 2'd1,
    REG_COEFF_LINEAR = 2'd2,
    REG_COEFF_CONST  = 2'd3
  } reg_idx_t;

  localparam logic [STEP_WIDTH-1:0] RST_STEP_SIZE    = 31'd167772;
  localparam value_t                RST_COEFF_SQUARE = 32'sd33554432;
  localparam value_t                RST_COEFF_LINEAR = -32'sd16777216;
  localparam value_t                RST_COEFF_CONST  = 32'sd16777216;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE   = 3'd0,
    MUL_A2_ARG = 3'd1,
    MUL_T_ARG  = 3'd2,
    MUL_A1_ARG = 3'd3,
    MUL_H_T    = 3'd4,
    MUL_DIV6   = 3'd5
  } mul_sel_t;

  typedef enum logic [2:0] {
    WR_NONE        = 3'd0,
    WR_ARG         = 3'd1,
    WR_T_PROD      = 3'd2,
    WR_T_ADD_PROD  = 3'd3,
    WR_T_ADD_CONST = 3'd4,
    WR_K           = 3'd5,
    WR_SUM         = 3'd6,
    WR_Y           = 3'd7
  } wr_sel_t;

  typedef enum logic [1:0] {
    J_NEXT  = 2'd0,
    J_STAGE = 2'd1,
    J_STEP  = 2'd2
  } jmp_t;

  typedef struct packed {
    mul_sel_t mul;
    wr_sel_t  wr;
    jmp_t     jmp;
  } ucode_t;

  localparam int UCODE_LEN = 12;
  typedef logic [$clog2(UCODE_LEN)-1:0] pc_t;

  localparam ucode_t UCODE [UCODE_LEN] = '{
    '{MUL_NONE,   WR_ARG,         J_NEXT},
    '{MUL_A2_ARG, WR_NONE,        J_NEXT},
    '{MUL_NONE,   WR_T_PROD,      J_NEXT},
    '{MUL_T_ARG,  WR_NONE,        J_NEXT},
    '{MUL_A1_ARG, WR_T_PROD,      J_NEXT},
    '{MUL_NONE,   WR_T_ADD_PROD,  J_NEXT},
    '{MUL_NONE,   WR_T_ADD_CONST, J_NEXT},
    '{MUL_H_T,    WR_NONE,        J_NEXT},
    '{MUL_NONE,   WR_K,           J_NEXT},
    '{MUL_NONE,   WR_SUM,         J_STAGE},
    '{MUL_DIV6,   WR_NONE,        J_NEXT},
    '{MUL_NONE,   WR_Y,           J_STEP}
  };

  typedef struct packed {
    logic   ovf;
    value_t val;
  } sat_t;

  function automatic sat_t sat_add(input value_t a, input value_t b);
    logic [VALUE_WIDTH:0] s;
    sat_t r;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    r.ovf = s[VALUE_WIDTH] ^ s[VALUE_WIDTH-1];
    r.val = r.ovf ? (s[VALUE_WIDTH] ? VMIN : VMAX) : value_t'(s[VALUE_WIDTH-1:0]);
    return r;
  endfunction

  function automatic umag_t mag(input value_t v);
    return v[VALUE_WIDTH-1] ? umag_t'(0) - umag_t'(v) : umag_t'(v);
  endfunction

  function automatic value_t half_trunc(input value_t v);
    value_t inc;
    inc = value_t'({{(VALUE_WIDTH-1){1'b0}}, v[VALUE_WIDTH-1]});
    return (v + inc) >>> 1;
  endfunction

  // product magnitude to fixed point, round half away from zero, saturate
  function automatic sat_t round_prod(input prod_t p, input logic neg);
    prod_t r;
    prod_t q;
    prod_t lim;
    sat_t  res;
    r   = p + (prod_t'(1) << (FRAC_BITS - 1));
    q   = r >> FRAC_BITS;
    lim = (prod_t'(1) << (VALUE_WIDTH - 1)) - prod_t'(!neg);
    res.ovf = q > lim;
    if (res.ovf) begin
      res.val = neg ? VMIN : VMAX;
    end else begin
      res.val = neg ? -value_t'(q[VALUE_WIDTH-1:0]) : value_t'(q[VALUE_WIDTH-1:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/rk4_quadratic_ode_integrator.sv]
// rk4 integrator top level: apb registers, microcode sequencer and shared multiplier datapath
// a transaction with n steps runs n rk4 steps; n = 0 goes straight from idle to done
// each rk4 step runs the 12-word microcode program with the slope part four times,
//   all paced by the one shared 32x32 multiplier and its rounding stage
// a new item is taken only in idle, once the last item's steps are done, and may be taken while its result waits
// reset: synchronous rst clears control state and loads default step size and coefficients
`default_nettype none

module rk4_quadratic_ode_integrator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire rk4_pkg::value_t                  start_value,
  input  wire rk4_pkg::steps_t                  step_count,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output rk4_pkg::value_t                       end_value,
  output logic                                  overflow,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rk4_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import rk4_pkg::*;

  logic [STEP_WIDTH-1:0] step_size;
  value_t coeff_square, coeff_linear, coeff_const;

  state_t state, state_next;
  pc_t    pc, pc_next;
  stage_t stage, stage_next;
  steps_t steps_left, steps_next;
  value_t y, y_next, arg, arg_next, t, t_next, k, k_next, sum, sum_next;
  logic   flag, flag_next;
  prod_t  prod;
  logic   prod_neg;

  ucode_t uc;
  steps_t steps_init;
  umag_t  mul_a, mul_b;
  logic   mul_neg;
  sat_t   prod_r;
  umag_t  quot;
  value_t div6;
  logic   out_free;
  logic   cfg_wr;
  reg_idx_t cfg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= RST_STEP_SIZE;
      coeff_square <= RST_COEFF_SQUARE;
      coeff_linear <= RST_COEFF_LINEAR;
      coeff_const  <= RST_COEFF_CONST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_SIZE:    step_size    <= pwdata[STEP_WIDTH-1:0];
        REG_COEFF_SQUARE: coeff_square <= value_t'(pwdata);
        REG_COEFF_LINEAR: coeff_linear <= value_t'(pwdata);
        REG_COEFF_CONST:  coeff_const  <= value_t'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STEP_SIZE:    prdata = {1'b0, step_size};
      REG_COEFF_SQUARE: prdata = coeff_square;
      REG_COEFF_LINEAR: prdata = coeff_linear;
      REG_COEFF_CONST:  prdata = coeff_const;
      default:          prdata = '0;
    endcase
  end

  // sequencer
  assign uc         = UCODE[pc];
  assign steps_init = (step_count > steps_t'(MAX_STEPS)) ? steps_t'(MAX_STEPS) : step_count;
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (steps_init == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (uc.jmp == J_STEP && steps_left == steps_t'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (uc.mul)
      MUL_A2_ARG: begin
        mul_a   = mag(coeff_square);
        mul_b   = mag(arg);
        mul_neg = coeff_square[VALUE_WIDTH-1] ^ arg[VALUE_WIDTH-1];
      end
      MUL_T_ARG: begin
        mul_a   = mag(t);
        mul_b   = mag(arg);
        mul_neg = t[VALUE_WIDTH-1] ^ arg[VALUE_WIDTH-1];
      end
      MUL_A1_ARG: begin
        mul_a   = mag(coeff_linear);
        mul_b   = mag(arg);
        mul_neg = coeff_linear[VALUE_WIDTH-1] ^ arg[VALUE_WIDTH-1];
      end
      MUL_H_T: begin
        mul_a   = umag_t'(step_size);
        mul_b   = mag(t);
        mul_neg = t[VALUE_WIDTH-1];
      end
      MUL_DIV6: begin
        mul_a   = RECIP3;
        mul_b   = mag(sum) >> 1;
        mul_neg = sum[VALUE_WIDTH-1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN && uc.mul != MUL_NONE) begin
      prod     <= prod_t'(mul_a) * prod_t'(mul_b);
      prod_neg <= mul_neg;
    end
  end

  assign prod_r = round_prod(prod, prod_neg);
  assign quot   = prod[PROD_WIDTH-1:VALUE_WIDTH];
  assign div6   = sum[VALUE_WIDTH-1] ? -value_t'(quot) : value_t'(quot);

  // datapath and step control
  always_comb begin
    sat_t s1;
    sat_t s2;
    y_next     = y;
    arg_next   = arg;
    t_next     = t;
    k_next     = k;
    sum_next   = sum;
    flag_next  = flag;
    steps_next = steps_left;
    stage_next = stage;
    pc_next    = pc;
    s1         = '0;
    s2         = '0;
    if (state == S_IDLE && in_valid) begin
      y_next     = start_value;
      steps_next = steps_init;
      flag_next  = 1'b0;
      stage_next = '0;
      pc_next    = '0;
    end else if (state == S_RUN) begin
      case (uc.wr)
        WR_ARG: begin
          if (stage == '0) begin
            arg_next = y;
          end else begin
            s1        = sat_add(y, (stage == LAST_STAGE) ? k : half_trunc(k));
            arg_next  = s1.val;
            flag_next = flag | s1.ovf;
          end
        end
        WR_T_PROD: begin
          t_next    = prod_r.val;
          flag_next = flag | prod_r.ovf;
        end
        WR_T_ADD_PROD: begin
          s1        = sat_add(t, prod_r.val);
          t_next    = s1.val;
          flag_next = flag | prod_r.ovf | s1.ovf;
        end
        WR_T_ADD_CONST: begin
          s1        = sat_add(t, coeff_const);
          t_next    = s1.val;
          flag_next = flag | s1.ovf;
        end
        WR_K: begin
          k_next    = prod_r.val;
          flag_next = flag | prod_r.ovf;
        end
        WR_SUM: begin
          if (stage == '0) begin
            sum_next = k;
          end else if (stage == LAST_STAGE) begin
            s2        = sat_add(sum, k);
            sum_next  = s2.val;
            flag_next = flag | s2.ovf;
          end else begin
            s1        = sat_add(k, k);
            s2        = sat_add(sum, s1.val);
            sum_next  = s2.val;
            flag_next = flag | s1.ovf | s2.ovf;
          end
        end
        WR_Y: begin
          s1        = sat_add(y, div6);
          y_next    = s1.val;
          flag_next = flag | s1.ovf;
        end
        default: ;
      endcase
      case (uc.jmp)
        J_NEXT: pc_next = pc + pc_t'(1);
        J_STAGE: begin
          if (stage == LAST_STAGE) begin
            pc_next = pc + pc_t'(1);
          end else begin
            pc_next    = '0;
            stage_next = stage + stage_t'(1);
          end
        end
        J_STEP: begin
          pc_next    = '0;
          stage_next = '0;
          steps_next = steps_left - steps_t'(1);
        end
        default: pc_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pc         <= '0;
      stage      <= '0;
      steps_left <= '0;
      flag       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pc         <= pc_next;
      stage      <= stage_next;
      steps_left <= steps_next;
      flag       <= flag_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    y   <= y_next;
    arg <= arg_next;
    t   <= t_next;
    k   <= k_next;
    sum <= sum_next;
    if (state == S_DONE && out_free) begin
      end_value <= y;
      overflow  <= flag;
    end
  end

  // checks
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> pc < pc_t'(UCODE_LEN))
    else $error("microcode pc out of range");

  a_run_has_steps: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> steps_left != '0)
    else $error("running with no steps left");

  a_zero_steps: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && step_count == '0 |=> state == S_DONE)
    else $error("zero step transaction did not finish at once");

endmodule

`default_nettype wire
